### rtl/core/affine_rect_bounding_box_top_macros.svh
// assertion macros used by the bounding box top module
`ifndef AFFINE_RECT_BOUNDING_BOX_TOP_MACROS_SVH
`define AFFINE_RECT_BOUNDING_BOX_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ARBB_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define ARBB_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/core/arbb_pkg.sv
// shared types, register indexes and width helpers for the bounding box block
`timescale 1ns / 1ps

package arbb_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_X_FROM_X = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_X_FROM_Y = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_X_OFFSET = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_Y_FROM_X = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_Y_FROM_Y = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_Y_OFFSET = 3'd5;

    localparam int COEF_BITS = 32;

    // load enables for the stages inside one axis unit
    typedef struct packed {
        logic mul;
        logic minmax;
        logic sum;
        logic round;
    } arbb_stage_en_t;

    // width that holds rounded coordinates, clipped origins and their difference
    function automatic int arbb_ext_width(input int coord_bits, input int frac_bits);
        int fw;
        fw = coord_bits + 36 - frac_bits;
        return ((fw > 32) ? fw : 32) + 2;
    endfunction

endpackage

### rtl/core/affine_rect_bounding_box_top.sv
// path: input transaction to out_valid through a 6-stage register chain
// throughput: one rectangle per cycle while the output is not stalled; the corner multipliers sit alone in stage 2
// a stalled output backs up stage by stage, empty stages still take new transactions
// reset: valid bits cleared, matrix registers back to identity with zero offset
// config writes are taken every cycle; indexes past the last register are dropped
`timescale 1ns / 1ps
`include "affine_rect_bounding_box_top_macros.svh"

module affine_rect_bounding_box_top #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [arbb_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [31:0]                          cfg_data,
    // rectangle channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [COORD_BITS-1:0]         rect_x,
    input  logic signed [COORD_BITS-1:0]         rect_y,
    input  logic [COORD_BITS-1:0]                rect_w,
    input  logic [COORD_BITS-1:0]                rect_h,
    // bounding box channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [31:0]                   box_x,
    output logic signed [31:0]                   box_y,
    output logic [31:0]                          box_w,
    output logic [31:0]                          box_h,
    output logic                                 saturated
);
    import arbb_pkg::*;

    localparam int CB = COORD_BITS + 2;
    localparam int EW = arbb_ext_width(COORD_BITS, FRAC_BITS);

    localparam logic signed [31:0]   COEF_ONE = 32'(64'(1) << FRAC_BITS);
    localparam logic signed [EW-1:0] U32_MAX  = {{(EW-32){1'b0}}, 32'hffff_ffff};

    // matrix registers
    logic signed [31:0] x_from_x_reg, x_from_y_reg, x_offset_reg;
    logic signed [31:0] y_from_x_reg, y_from_y_reg, y_offset_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_from_x_reg <= COEF_ONE;
            x_from_y_reg <= '0;
            x_offset_reg <= '0;
            y_from_x_reg <= '0;
            y_from_y_reg <= COEF_ONE;
            y_offset_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_X_FROM_X: x_from_x_reg <= cfg_data;
                REG_X_FROM_Y: x_from_y_reg <= cfg_data;
                REG_X_OFFSET: x_offset_reg <= cfg_data;
                REG_Y_FROM_X: y_from_x_reg <= cfg_data;
                REG_Y_FROM_Y: y_from_y_reg <= cfg_data;
                REG_Y_OFFSET: y_offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits and per-stage load enables, a stage moves when the next one frees up
    logic [6:1] valid_reg;
    logic [6:1] stage_load;

    assign stage_load[6] = !valid_reg[6] || out_ready;
    assign stage_load[5] = !valid_reg[5] || stage_load[6];
    assign stage_load[4] = !valid_reg[4] || stage_load[5];
    assign stage_load[3] = !valid_reg[3] || stage_load[4];
    assign stage_load[2] = !valid_reg[2] || stage_load[3];
    assign stage_load[1] = !valid_reg[1] || stage_load[2];
    assign in_ready      = stage_load[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_load[1]) valid_reg[1] <= in_valid;
            if (stage_load[2]) valid_reg[2] <= valid_reg[1];
            if (stage_load[3]) valid_reg[3] <= valid_reg[2];
            if (stage_load[4]) valid_reg[4] <= valid_reg[3];
            if (stage_load[5]) valid_reg[5] <= valid_reg[4];
            if (stage_load[6]) valid_reg[6] <= valid_reg[5];
        end
    end

    // stage 1: far corner coordinates
    logic signed [CB-1:0] x1_next, x2_next, y1_next, y2_next;
    logic signed [CB-1:0] x1_reg, x2_reg, y1_reg, y2_reg;

    assign x1_next = {{2{rect_x[COORD_BITS-1]}}, rect_x};
    assign y1_next = {{2{rect_y[COORD_BITS-1]}}, rect_y};
    assign x2_next = x1_next + $signed({2'b00, rect_w});
    assign y2_next = y1_next + $signed({2'b00, rect_h});

    always_ff @(posedge clk)
    begin
        if (stage_load[1])
        begin
            x1_reg <= x1_next;
            x2_reg <= x2_next;
            y1_reg <= y1_next;
            y2_reg <= y2_next;
        end
    end

    // stages 2 to 5: one unit per output axis
    arbb_stage_en_t axis_en;

    assign axis_en.mul    = stage_load[2];
    assign axis_en.minmax = stage_load[3];
    assign axis_en.sum    = stage_load[4];
    assign axis_en.round  = stage_load[5];

    logic signed [31:0]   org_x, org_y;
    logic                 org_x_sat, org_y_sat;
    logic signed [EW-1:0] ceil_x, ceil_y;

    arbb_axis #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_axis_x (
        .clk        (clk),
        .stage_en   (axis_en),
        .weight_x   (x_from_x_reg),
        .weight_y   (x_from_y_reg),
        .offset     (x_offset_reg),
        .x1         (x1_reg),
        .x2         (x2_reg),
        .y1         (y1_reg),
        .y2         (y2_reg),
        .origin     (org_x),
        .origin_sat (org_x_sat),
        .ceil_hi    (ceil_x)
    );

    arbb_axis #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_axis_y (
        .clk        (clk),
        .stage_en   (axis_en),
        .weight_x   (y_from_x_reg),
        .weight_y   (y_from_y_reg),
        .offset     (y_offset_reg),
        .x1         (x1_reg),
        .x2         (x2_reg),
        .y1         (y1_reg),
        .y2         (y2_reg),
        .origin     (org_y),
        .origin_sat (org_y_sat),
        .ceil_hi    (ceil_y)
    );

    // stage 6: size from the clipped origin, clipped to unsigned 32 bits
    logic signed [EW-1:0] diff_w, diff_h;
    logic [31:0]          box_w_next, box_h_next;
    logic                 sat_w, sat_h, sat_next;

    assign diff_w = ceil_x - {{(EW-32){org_x[31]}}, org_x};
    assign diff_h = ceil_y - {{(EW-32){org_y[31]}}, org_y};

    always_comb
    begin
        sat_w      = 1'b0;
        sat_h      = 1'b0;
        box_w_next = diff_w[31:0];
        box_h_next = diff_h[31:0];
        if (diff_w < 0)
        begin
            sat_w      = 1'b1;
            box_w_next = '0;
        end
        else if (diff_w > U32_MAX)
        begin
            sat_w      = 1'b1;
            box_w_next = '1;
        end
        if (diff_h < 0)
        begin
            sat_h      = 1'b1;
            box_h_next = '0;
        end
        else if (diff_h > U32_MAX)
        begin
            sat_h      = 1'b1;
            box_h_next = '1;
        end
    end

    assign sat_next = org_x_sat || org_y_sat || sat_w || sat_h;

    logic signed [31:0] box_x_reg, box_y_reg;
    logic [31:0]        box_w_reg, box_h_reg;
    logic               saturated_reg;

    always_ff @(posedge clk)
    begin
        if (stage_load[6])
        begin
            box_x_reg     <= org_x;
            box_y_reg     <= org_y;
            box_w_reg     <= box_w_next;
            box_h_reg     <= box_h_next;
            saturated_reg <= sat_next;
        end
    end

    assign out_valid = valid_reg[6];
    assign box_x     = box_x_reg;
    assign box_y     = box_y_reg;
    assign box_w     = box_w_reg;
    assign box_h     = box_h_reg;
    assign saturated = saturated_reg;

    // pipeline checks
    `ARBB_ASSERT_NOW(a_ready_only_when_full, clk, rst_n, !in_ready, &valid_reg,
        "input stalled while a pipeline stage is empty")
    `ARBB_ASSERT_NEXT(a_accept_lands, clk, rst_n, in_valid && in_ready, valid_reg[1],
        "accepted transaction missing from stage 1")
    `ARBB_ASSERT_NEXT(a_stall_keeps_stage5, clk, rst_n,
        valid_reg[5] && valid_reg[6] && !out_ready, valid_reg[5] && valid_reg[6],
        "transaction lost behind a stalled output")
    `ARBB_ASSERT_NEXT(a_no_repeat, clk, rst_n,
        out_valid && out_ready && !valid_reg[5], !out_valid,
        "result delivered twice")

endmodule

### rtl/core/arbb_axis.sv
// one output axis: corner products, min and max, offset sum, floor and ceiling
`timescale 1ns / 1ps

module arbb_axis #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                                   clk,
    input  arbb_pkg::arbb_stage_en_t                               stage_en,
    input  logic signed [31:0]                                     weight_x,
    input  logic signed [31:0]                                     weight_y,
    input  logic signed [31:0]                                     offset,
    input  logic signed [COORD_BITS+1:0]                           x1,
    input  logic signed [COORD_BITS+1:0]                           x2,
    input  logic signed [COORD_BITS+1:0]                           y1,
    input  logic signed [COORD_BITS+1:0]                           y2,
    output logic signed [31:0]                                     origin,
    output logic                                                   origin_sat,
    output logic signed [arbb_pkg::arbb_ext_width(COORD_BITS, FRAC_BITS)-1:0] ceil_hi
);
    import arbb_pkg::*;

    localparam int CB = COORD_BITS + 2;
    localparam int PW = COEF_BITS + CB;
    localparam int SW = PW + 2;
    localparam int FW = SW - FRAC_BITS;
    localparam int EW = arbb_ext_width(COORD_BITS, FRAC_BITS);

    localparam logic signed [SW-1:0] FRAC_MASK = {{(SW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
    localparam logic signed [EW-1:0] S32_MAX   = {{(EW-32){1'b0}}, 32'h7fff_ffff};
    localparam logic signed [EW-1:0] S32_MIN   = {{(EW-32){1'b1}}, 32'h8000_0000};

    // stage 2: the four weighted corner terms
    logic signed [PW-1:0] px1_next, px2_next, py1_next, py2_next;
    logic signed [PW-1:0] px1_reg, px2_reg, py1_reg, py2_reg;

    assign px1_next = weight_x * x1;
    assign px2_next = weight_x * x2;
    assign py1_next = weight_y * y1;
    assign py2_next = weight_y * y2;

    always_ff @(posedge clk)
    begin
        if (stage_en.mul)
        begin
            px1_reg <= px1_next;
            px2_reg <= px2_next;
            py1_reg <= py1_next;
            py2_reg <= py2_next;
        end
    end

    // stage 3: min and max of each pair of terms, the map is separable in x and y
    logic signed [PW-1:0] xmin_next, xmax_next, ymin_next, ymax_next;
    logic signed [PW-1:0] xmin_reg, xmax_reg, ymin_reg, ymax_reg;

    assign xmin_next = (px1_reg < px2_reg) ? px1_reg : px2_reg;
    assign xmax_next = (px1_reg < px2_reg) ? px2_reg : px1_reg;
    assign ymin_next = (py1_reg < py2_reg) ? py1_reg : py2_reg;
    assign ymax_next = (py1_reg < py2_reg) ? py2_reg : py1_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en.minmax)
        begin
            xmin_reg <= xmin_next;
            xmax_reg <= xmax_next;
            ymin_reg <= ymin_next;
            ymax_reg <= ymax_next;
        end
    end

    // stage 4: smallest and largest mapped coordinate
    logic signed [SW-1:0] lo_next, hi_next, lo_reg, hi_reg, off_ext;

    assign off_ext = {{(SW-32){offset[31]}}, offset};
    assign lo_next = {{2{xmin_reg[PW-1]}}, xmin_reg} + {{2{ymin_reg[PW-1]}}, ymin_reg} + off_ext;
    assign hi_next = {{2{xmax_reg[PW-1]}}, xmax_reg} + {{2{ymax_reg[PW-1]}}, ymax_reg} + off_ext;

    always_ff @(posedge clk)
    begin
        if (stage_en.sum)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    // stage 5: floor of the minimum clipped to 32 bits, ceiling of the maximum
    logic signed [FW-1:0] flo;
    logic signed [SW-1:0] hi_up;
    logic signed [FW-1:0] chi;
    logic signed [EW-1:0] flo_ext;
    logic signed [31:0]   origin_next, origin_reg;
    logic                 origin_sat_next, origin_sat_reg;
    logic signed [EW-1:0] ceil_hi_next, ceil_hi_reg;

    assign flo          = lo_reg[SW-1:FRAC_BITS];
    assign hi_up        = hi_reg + FRAC_MASK;
    assign chi          = hi_up[SW-1:FRAC_BITS];
    assign flo_ext      = {{(EW-FW){flo[FW-1]}}, flo};
    assign ceil_hi_next = {{(EW-FW){chi[FW-1]}}, chi};

    always_comb
    begin
        origin_sat_next = 1'b0;
        origin_next     = flo_ext[31:0];
        if (flo_ext > S32_MAX)
        begin
            origin_sat_next = 1'b1;
            origin_next     = S32_MAX[31:0];
        end
        else if (flo_ext < S32_MIN)
        begin
            origin_sat_next = 1'b1;
            origin_next     = S32_MIN[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en.round)
        begin
            origin_reg     <= origin_next;
            origin_sat_reg <= origin_sat_next;
            ceil_hi_reg    <= ceil_hi_next;
        end
    end

    assign origin     = origin_reg;
    assign origin_sat = origin_sat_reg;
    assign ceil_hi    = ceil_hi_reg;

endmodule

### tb/sv/testbench.sv
// self-checking testbench for the affine rectangle bounding box block
`timescale 1ns / 1ps

module testbench;
    import arbb_pkg::*;

    localparam int COORD_BITS     = 16;
    localparam int FRAC_BITS      = 16;
    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 100;
    localparam int MAX_GAP        = 40;

    localparam int RANDOM_PHASES      = 4;
    localparam int MATRICES_PER_PHASE = 4;
    localparam int RECTS_PER_MATRIX   = 60;

    localparam longint FRAC_MASK = (64'sd1 <<< FRAC_BITS) - 64'sd1;
    localparam longint S32_MIN   = -64'sd2147483648;
    localparam longint S32_MAX   = 64'sd2147483647;
    localparam longint U32_MAX   = 64'sd4294967295;

    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0]        EXTENT_MAX = '1;

    localparam logic [31:0] COEF_ONE = 32'h0001_0000;
    localparam logic [31:0] COEF_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] COEF_MIN = 32'h8000_0000;

    // indexes past the last matrix register
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_LO = REG_Y_OFFSET + 1'b1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_HI = '1;

    typedef struct {
        logic signed [31:0] org_x;
        logic signed [31:0] org_y;
        logic [31:0]        ext_w;
        logic [31:0]        ext_h;
        logic               clipped;
    } bound_box_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_INDEX_BITS-1:0]     cfg_index = '0;
    logic [31:0]                   cfg_data  = '0;

    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic signed [COORD_BITS-1:0]  rect_x = '0;
    logic signed [COORD_BITS-1:0]  rect_y = '0;
    logic [COORD_BITS-1:0]         rect_w = '0;
    logic [COORD_BITS-1:0]         rect_h = '0;

    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [31:0]            box_x;
    logic signed [31:0]            box_y;
    logic [31:0]                   box_w;
    logic [31:0]                   box_h;
    logic                          saturated;

    // own copy of the matrix registers and the boxes still to come out
    logic signed [31:0] matrix_coef [0:5];
    bound_box_t         expected_boxes [$];

    int error_count        = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int quiet_cycles       = 0;

    affine_rect_bounding_box_top #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rect_x    (rect_x),
        .rect_y    (rect_y),
        .rect_w    (rect_w),
        .rect_h    (rect_h),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .box_x     (box_x),
        .box_y     (box_y),
        .box_w     (box_w),
        .box_h     (box_h),
        .saturated (saturated)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // min and max of one mapped axis over the four corners, exact fixed point
    function automatic void map_axis(input longint a, input longint b, input longint c,
                                     input longint x1, input longint x2,
                                     input longint y1, input longint y2,
                                     output longint lo, output longint hi);
        longint corner [4];
        int     i;
        corner[0] = a * x1 + b * y1 + c;
        corner[1] = a * x2 + b * y1 + c;
        corner[2] = a * x2 + b * y2 + c;
        corner[3] = a * x1 + b * y2 + c;
        lo = corner[0];
        hi = corner[0];
        for (i = 1; i < 4; i++)
        begin
            if (corner[i] < lo)
                lo = corner[i];
            if (corner[i] > hi)
                hi = corner[i];
        end
    endfunction

    function automatic longint clip_range(input longint v, input longint lo, input longint hi,
                                          output logic hit);
        hit = (v < lo) || (v > hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic bound_box_t predict_box(input logic signed [COORD_BITS-1:0] x,
                                               input logic signed [COORD_BITS-1:0] y,
                                               input logic [COORD_BITS-1:0] w,
                                               input logic [COORD_BITS-1:0] h);
        bound_box_t box;
        longint     x1, y1, x2, y2, xlo, xhi, ylo, yhi, left, top, width, height;
        logic [3:0] hit;
        x1 = x;
        y1 = y;
        x2 = x1 + longint'(w);
        y2 = y1 + longint'(h);
        map_axis(matrix_coef[REG_X_FROM_X], matrix_coef[REG_X_FROM_Y], matrix_coef[REG_X_OFFSET],
                 x1, x2, y1, y2, xlo, xhi);
        map_axis(matrix_coef[REG_Y_FROM_X], matrix_coef[REG_Y_FROM_Y], matrix_coef[REG_Y_OFFSET],
                 x1, x2, y1, y2, ylo, yhi);
        // floor of the minima, clipped to the signed range
        left = clip_range(xlo >>> FRAC_BITS, S32_MIN, S32_MAX, hit[0]);
        top  = clip_range(ylo >>> FRAC_BITS, S32_MIN, S32_MAX, hit[1]);
        // ceiling of the maxima, measured from the clipped origin
        width  = clip_range(((xhi + FRAC_MASK) >>> FRAC_BITS) - left, 0, U32_MAX, hit[2]);
        height = clip_range(((yhi + FRAC_MASK) >>> FRAC_BITS) - top, 0, U32_MAX, hit[3]);
        box.org_x   = left[31:0];
        box.org_y   = top[31:0];
        box.ext_w   = width[31:0];
        box.ext_h   = height[31:0];
        box.clipped = |hit;
        return box;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("error at %0t ns: %s", $time, msg);
    endtask

    // one rectangle transaction; valid is left high so the next one can follow directly
    task automatic send_rect(input logic signed [COORD_BITS-1:0] x,
                             input logic signed [COORD_BITS-1:0] y,
                             input logic [COORD_BITS-1:0] w,
                             input logic [COORD_BITS-1:0] h);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rect_x   <= x;
        rect_y   <= y;
        rect_w   <= w;
        rect_h   <= h;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_boxes = {expected_boxes, predict_box(x, y, w, h)};
    endtask

    // one register write; the caller lowers cfg_valid after the last one
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx <= REG_Y_OFFSET)
            matrix_coef[idx] = data;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_boxes.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_matrix(input logic [31:0] xx, input logic [31:0] xy,
                               input logic [31:0] xo, input logic [31:0] yx,
                               input logic [31:0] yy, input logic [31:0] yo);
        wait_idle();
        write_reg(REG_X_FROM_X, xx);
        write_reg(REG_X_FROM_Y, xy);
        write_reg(REG_X_OFFSET, xo);
        write_reg(REG_Y_FROM_X, yx);
        write_reg(REG_Y_FROM_Y, yy);
        write_reg(REG_Y_OFFSET, yo);
        // a write past the last register must leave the matrix alone
        write_reg(($urandom_range(0, 1) != 0) ? REG_UNUSED_LO : REG_UNUSED_HI, $urandom);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_coef();
        case ($urandom_range(0, 6))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return '0;
            3: return $urandom;
            default: return $signed($urandom) >>> $urandom_range(4, 28);
        endcase
    endfunction

    function automatic logic [COORD_BITS-1:0] random_coord();
        int near;
        near = $urandom_range(0, 1023);
        if ($urandom_range(0, 2) == 0)
            return COORD_BITS'($urandom);
        return COORD_BITS'(near - 512);
    endfunction

    function automatic logic [COORD_BITS-1:0] random_extent();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return COORD_BITS'($urandom_range(1, 16));
            2: return COORD_BITS'($urandom_range(0, 1023));
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    // identity matrix from reset, corner cases of the rectangle fields
    task automatic test_reset_matrix_extremes();
        send_rect(0, 0, 0, 0);
        send_rect(COORD_MIN, COORD_MIN, 0, 0);
        send_rect(COORD_MAX, COORD_MAX, EXTENT_MAX, EXTENT_MAX);
        send_rect(COORD_MIN, COORD_MAX, EXTENT_MAX, 0);
        send_rect(COORD_MAX, COORD_MIN, 0, EXTENT_MAX);
        send_rect(COORD_MIN, COORD_MIN, EXTENT_MAX, EXTENT_MAX);
        send_rect(-1, -1, 1, 1);
        send_rect(5, -7, 10, 3);
    endtask

    // each register on its own, then the unused indexes
    task automatic test_register_writes();
        int                        i;
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [31:0]               value;
        for (i = REG_X_FROM_X; i <= REG_UNUSED_HI; i++)
        begin
            idx = i[CFG_INDEX_BITS-1:0];
            case (idx)
                REG_X_FROM_X: value = 32'h0001_8000;
                REG_X_FROM_Y: value = 32'hFFFF_4000;
                REG_X_OFFSET: value = 32'h0003_2000;
                REG_Y_FROM_X: value = 32'h0000_0001;
                REG_Y_FROM_Y: value = 32'hFFFE_0000;
                REG_Y_OFFSET: value = 32'hFFFF_FFFF;
                default:      value = $urandom;
            endcase
            wait_idle();
            write_reg(idx, value);
            cfg_valid <= 1'b0;
            send_rect(3, -4, 17, 9);
        end
    endtask

    // extreme matrices: clipped origins, clipped sizes, sizes gone negative
    task automatic test_saturation();
        int m;
        for (m = 0; m < 3; m++)
        begin
            case (m)
                0: load_matrix(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
                1: load_matrix(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
                default: load_matrix(COEF_MAX, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MAX, COEF_MIN);
            endcase
            send_rect(COORD_MAX, COORD_MAX, EXTENT_MAX, EXTENT_MAX);
            send_rect(COORD_MIN, COORD_MIN, 0, 0);
            send_rect(COORD_MIN, COORD_MAX, EXTENT_MAX, 0);
        end
    endtask

    // random matrices and rectangles under each idling pattern
    task automatic test_random_traffic();
        int phase, m, n;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 50;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 50;
                end
                default:
                begin
                    sender_idle_pct    = 6;
                    receiver_stall_pct = 6;
                end
            endcase
            for (m = 0; m < MATRICES_PER_PHASE; m++)
            begin
                load_matrix(random_coef(), random_coef(), random_coef(),
                            random_coef(), random_coef(), random_coef());
                for (n = 0; n < RECTS_PER_MATRIX; n++)
                    send_rect(random_coord(), random_coord(), random_extent(), random_extent());
            end
        end
    endtask

    // receiver back-pressure
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);

    // compare each box transaction with the oldest prediction
    always @(posedge clk)
    begin : check_box
        bound_box_t want;
        if (out_valid && out_ready)
        begin
            if (expected_boxes.size() == 0)
            begin
                report_error($sformatf("unexpected box x=%0d y=%0d w=%0d h=%0d sat=%0b",
                                       box_x, box_y, box_w, box_h, saturated));
            end
            else
            begin
                want = expected_boxes.pop_front();
                if (box_x !== want.org_x)
                    report_error($sformatf("box_x got %0d expected %0d", box_x, want.org_x));
                if (box_y !== want.org_y)
                    report_error($sformatf("box_y got %0d expected %0d", box_y, want.org_y));
                if (box_w !== want.ext_w)
                    report_error($sformatf("box_w got %0d expected %0d", box_w, want.ext_w));
                if (box_h !== want.ext_h)
                    report_error($sformatf("box_h got %0d expected %0d", box_h, want.ext_h));
                if (saturated !== want.clipped)
                    report_error($sformatf("saturated got %0b expected %0b",
                                           saturated, want.clipped));
            end
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        // matrix after reset: identity with zero offset
        matrix_coef[REG_X_FROM_X] = COEF_ONE;
        matrix_coef[REG_X_FROM_Y] = '0;
        matrix_coef[REG_X_OFFSET] = '0;
        matrix_coef[REG_Y_FROM_X] = '0;
        matrix_coef[REG_Y_FROM_Y] = COEF_ONE;
        matrix_coef[REG_Y_OFFSET] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_matrix_extremes();
        test_register_writes();
        test_saturation();
        test_random_traffic();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
